// ===== rtl/core/cstrip_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Comment stripper package
// Shared byte codes, lexer modes and the queue entry format.
// ---------------------------------------------------------------------------
package cstrip_pkg;

  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;

  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [6:0] {
    ModeNormal    = 7'b0000001,
    ModeSlash     = 7'b0000010,
    ModeLine      = 7'b0000100,
    ModeBlock     = 7'b0001000,
    ModeBlockStar = 7'b0010000,
    ModeString    = 7'b0100000,
    ModeStringEsc = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/cstrip_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Comment stripper front end
// Accepts source bytes, tracks the lexer mode and packs the output bytes
// of each input byte into one queue entry.
// ---------------------------------------------------------------------------
module cstrip_front
  import cstrip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic      end_of_text_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output entry_t    push_entry_o
);

  mode_e  mode_q, mode_d;
  logic   accept;
  logic   emit;
  entry_t entry;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    mode_d       = mode_q;
    emit         = 1'b0;
    entry.two    = 1'b0;
    entry.first  = in_char_i;
    entry.second = in_char_i;
    unique case (mode_q)
      ModeSlash: begin
        if (in_char_i == ChSlash) begin
          mode_d = ModeLine;
        end else if (in_char_i == ChStar) begin
          mode_d = ModeBlock;
        end else begin
          emit        = 1'b1;
          entry.first = ChSlash;
          entry.two   = 1'b1;
          mode_d      = (in_char_i == ChQuote) ? ModeString : ModeNormal;
        end
      end
      ModeLine: begin
        if (in_char_i == ChNewline) begin
          emit   = 1'b1;
          mode_d = ModeNormal;
        end
      end
      ModeBlock: begin
        if (in_char_i == ChStar) begin
          mode_d = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (in_char_i == ChSlash) begin
          mode_d = ModeNormal;
        end else if (in_char_i != ChStar) begin
          mode_d = ModeBlock;
        end
      end
      ModeString: begin
        emit = 1'b1;
        if (in_char_i == ChBackslash) begin
          mode_d = ModeStringEsc;
        end else if (in_char_i == ChQuote) begin
          mode_d = ModeNormal;
        end
      end
      ModeStringEsc: begin
        emit   = 1'b1;
        mode_d = ModeString;
      end
      default: begin
        if (in_char_i == ChSlash && !end_of_text_i) begin
          mode_d = ModeSlash;
        end else begin
          emit   = 1'b1;
          mode_d = (in_char_i == ChQuote) ? ModeString : ModeNormal;
        end
      end
    endcase
    if (end_of_text_i) begin
      mode_d = ModeNormal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  assign push_o       = accept && emit;
  assign push_entry_o = entry;

endmodule

// ===== rtl/core/cstrip_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Comment stripper queue
// Short FIFO of packed output entries between front and back end.
// ---------------------------------------------------------------------------
module cstrip_queue
  import cstrip_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    push_entry_i,
  input  logic      pop_i,
  output entry_t    pop_entry_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign pop_entry_o    = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> !status_o.empty)
    else $error("queue empty after push");

endmodule

// ===== rtl/core/cstrip_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Comment stripper back end
// Drains queue entries into the output register, one byte per beat.
// ---------------------------------------------------------------------------
module cstrip_back
  import cstrip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  entry_t    pop_entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [7:0] out_char_o,
  output logic      run_last_o
);

  entry_t hold_q;
  logic   valid_q;
  logic   phase_q;
  logic   out_accept;
  logic   entry_done;

  assign out_accept = valid_q && !out_stall_i;
  assign entry_done = !hold_q.two || phase_q;
  assign pop_o      = !q_status_i.empty && (!valid_q || (out_accept && entry_done));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      phase_q <= 1'b0;
    end else if (out_accept) begin
      if (entry_done) begin
        valid_q <= 1'b0;
        phase_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hold_q <= pop_entry_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = phase_q ? hold_q.second : hold_q.first;
  assign run_last_o  = entry_done;

  a_phase_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && phase_q |-> hold_q.two)
    else $error("second byte phase on single-byte entry");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && !run_last_o |=> out_valid_o && run_last_o)
    else $error("second byte of run missing");

  a_pop_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !valid_q || (out_accept && run_last_o))
    else $error("output register overwritten");

endmodule

// ===== rtl/core/c_comment_stripper_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// C comment stripper
// Streams C source bytes and passes them on with comments removed.
// ---------------------------------------------------------------------------
// Takes one source byte per cycle while the queue is not full and gives zero,
// one or two output beats for it, with run_last marking the last beat of each
// byte. Output runs at one beat per cycle from the output register while
// out_stall is low, so the sustained rate is one byte per cycle except where a
// held slash is released together with the next byte in two output beats. An
// accepted byte is written into the queue by the lexer, then the back end
// loads it into the output register. The queue of QueueDepth entries lets
// input keep flowing while the output is stalled until it holds that many.
module c_comment_stripper_top
  import cstrip_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o
);

  q_status_t q_status;
  logic      push;
  entry_t    push_entry;
  logic      pop;
  entry_t    pop_entry;

  cstrip_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_char_i,
    .end_of_text_i,
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  cstrip_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .status_o     (q_status)
  );

  cstrip_back u_back (
    .clk_i,
    .rst_ni,
    .q_status_i  (q_status),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .run_last_o
  );

endmodule
